// ===== hdl/sst_pkg.sv =====
// Shared types, constants and keyword table for the screen spec tokenizer.
// Used by the channel interfaces, the tokenizer core, the result queue and the top level.
package sst_pkg;

    localparam int unsigned KEYWORD_MAX_LEN = 10;
    localparam int unsigned NAME_LEN_W = $clog2(KEYWORD_MAX_LEN + 2);

    localparam int unsigned CH_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned TOKEN_W = 4;
    localparam int unsigned NUM_W = 31;
    localparam int unsigned LINE_W = 16;
    localparam int unsigned ERR_W = 3;
    localparam int unsigned RES_MAX = 3;
    localparam int unsigned RES_CNT_W = 2;

    localparam logic [NUM_W-1:0] NUM_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_TEXT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOKEN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    localparam logic [TOKEN_W-1:0] TOK_SECTION_END = 4'd0;
    localparam logic [TOKEN_W-1:0] TOK_NEWLINE = 4'd1;
    localparam logic [TOKEN_W-1:0] TOK_NUMBER = 4'd2;
    localparam logic [TOKEN_W-1:0] TOK_NAME = 4'd3;
    localparam logic [TOKEN_W-1:0] TOK_STRING = 4'd4;
    localparam logic [TOKEN_W-1:0] TOK_KEYWORD_BASE = 4'd5;

    localparam logic [ERR_W-1:0] ERR_BAD_PERCENT = 3'd0;
    localparam logic [ERR_W-1:0] ERR_STRAY_BACKSLASH = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NEWLINE_IN_STRING = 3'd2;
    localparam logic [ERR_W-1:0] ERR_ILLEGAL_CHAR = 3'd3;
    localparam logic [ERR_W-1:0] ERR_UNEXPECTED_END = 3'd4;

    localparam int unsigned KW_COUNT = 11;
    localparam int unsigned KW_TEXT_BYTES = 10;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TOKEN_W-1:0] token;
        logic [CH_W-1:0]    text_char;
        logic [NUM_W-1:0]   number_value;
        logic [LINE_W-1:0]  line_number;
        logic [ERR_W-1:0]   error_code;
        logic               last;
    } result_t;

    typedef struct packed {
        logic                        valid;
        logic [RES_CNT_W-1:0]        cnt;
        result_t [RES_MAX-1:0]       res;
    } push_t;

    function automatic int unsigned kw_len(input int unsigned k);
        int unsigned len;
        case (k)
            0: len = 8;
            1: len = 8;
            2: len = 4;
            3: len = 7;
            4: len = 4;
            5: len = 5;
            6: len = 4;
            7: len = 6;
            8: len = 10;
            9: len = 2;
            10: len = 4;
            default: len = 0;
        endcase
        return len;
    endfunction

    function automatic logic [CH_W-1:0] kw_byte(input int unsigned k, input int unsigned i);
        logic [8*KW_TEXT_BYTES-1:0] w;
        int unsigned len;
        case (k)
            0: w = "external";
            1: w = "readonly";
            2: w = "long";
            3: w = "default";
            4: w = "skip";
            5: w = "group";
            6: w = "help";
            7: w = "verify";
            8: w = "designator";
            9: w = "do";
            10: w = "done";
            default: w = '0;
        endcase
        len = kw_len(k);
        if (i < len)
        begin
            return w[8*(len-1-i) +: 8];
        end
        return '0;
    endfunction

endpackage

// ===== hdl/sst_in_if.sv =====
// Input channel of the tokenizer: one character or end-of-input mark per transaction.
// Depends on sst_pkg for field widths.
interface sst_in_if;
    logic                       valid;
    logic                       ready;
    logic [sst_pkg::CH_W-1:0]   ch;
    logic                       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

// ===== hdl/sst_out_if.sv =====
// Output channel of the tokenizer: one text character, token or error per transaction.
// Depends on sst_pkg for field widths.
interface sst_out_if;
    logic                           valid;
    logic                           ready;
    logic [sst_pkg::KIND_W-1:0]     kind;
    logic [sst_pkg::TOKEN_W-1:0]    token;
    logic [sst_pkg::CH_W-1:0]       text_char;
    logic [sst_pkg::NUM_W-1:0]      number_value;
    logic [sst_pkg::LINE_W-1:0]     line_number;
    logic [sst_pkg::ERR_W-1:0]      error_code;
    logic                           last;

    modport source (output valid, output kind, output token, output text_char,
                    output number_value, output line_number, output error_code,
                    output last, input ready);
    modport sink (input valid, input kind, input token, input text_char,
                  input number_value, input line_number, input error_code,
                  input last, output ready);
endinterface

// ===== hdl/sst_core.sv =====
// Tokenizer core: input register, scanner state machine and keyword compare.
// Produces up to three results per character as one bundle; depends on sst_pkg, sst_in_if.
module sst_core
(
    input  logic            clk,
    input  logic            rst_n,
    sst_in_if.sink          chars,
    output sst_pkg::push_t  push,
    input  logic            free
);

    typedef enum logic [3:0]
    {
        M_START  = 4'd0,
        M_NAME   = 4'd1,
        M_NUM    = 4'd2,
        M_STR    = 4'd3,
        M_BSL    = 4'd4,
        M_COMM   = 4'd5,
        M_PCT    = 4'd6,
        M_PCTEND = 4'd7,
        M_HALT   = 4'd8
    } mode_t;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam int unsigned LW = sst_pkg::NAME_LEN_W;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic sst_pkg::result_t mk(
        input logic [sst_pkg::KIND_W-1:0]  kind,
        input logic [sst_pkg::TOKEN_W-1:0] tok,
        input logic [sst_pkg::CH_W-1:0]    text,
        input logic [sst_pkg::NUM_W-1:0]   num,
        input logic [sst_pkg::LINE_W-1:0]  line,
        input logic [sst_pkg::ERR_W-1:0]   err
    );
        sst_pkg::result_t r;
        r.kind = kind;
        r.token = tok;
        r.text_char = text;
        r.number_value = num;
        r.line_number = line;
        r.error_code = err;
        r.last = 1'b0;
        return r;
    endfunction

    logic                           in_valid_reg;
    logic [7:0]                     ch_reg;
    logic                           eoi_reg;

    mode_t                          mode_reg, mode_next;
    logic                           esc_reg, esc_next;
    logic [sst_pkg::LINE_W-1:0]     line_reg, line_next;
    logic [sst_pkg::NUM_W-1:0]      accum_reg, accum_next;
    logic [LW-1:0]                  len_reg, len_next;
    logic [7:0]                     store_reg [sst_pkg::KEYWORD_MAX_LEN];

    logic                           store_we;
    logic [LW-1:0]                  store_idx;
    logic [sst_pkg::TOKEN_W-1:0]    name_tok;
    logic [sst_pkg::LINE_W-1:0]     line_inc;
    logic [sst_pkg::NUM_W+3:0]      acc10;
    logic [3:0]                     digit;
    logic                           do_start;
    logic [sst_pkg::RES_CNT_W-1:0]  cnt;
    sst_pkg::result_t [sst_pkg::RES_MAX-1:0] res;
    logic                           fire;

    always_comb
    begin
        logic match;
        name_tok = sst_pkg::TOK_NAME;
        for (int k = sst_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            match = (len_reg == LW'(sst_pkg::kw_len(k)));
            for (int i = 0; i < sst_pkg::KEYWORD_MAX_LEN; i++)
            begin
                if (i < sst_pkg::kw_len(k) && store_reg[i] != sst_pkg::kw_byte(k, i))
                begin
                    match = 1'b0;
                end
            end
            if (match)
            begin
                name_tok = sst_pkg::TOKEN_W'(sst_pkg::TOK_KEYWORD_BASE + k);
            end
        end
    end

    assign line_inc = (line_reg == '1) ? line_reg : line_reg + 1'b1;
    assign digit = 4'(ch_reg - 8'h30);
    assign acc10 = (sst_pkg::NUM_W+4)'({accum_reg, 3'b000})
                 + (sst_pkg::NUM_W+4)'({accum_reg, 1'b0})
                 + (sst_pkg::NUM_W+4)'(digit);

    always_comb
    begin
        mode_next = mode_reg;
        esc_next = esc_reg;
        line_next = line_reg;
        accum_next = accum_reg;
        len_next = len_reg;
        store_we = 1'b0;
        store_idx = len_reg;
        do_start = 1'b0;
        cnt = '0;
        res = '0;

        if (mode_reg == M_HALT)
        begin
            mode_next = M_HALT;
        end
        else if (eoi_reg)
        begin
            res[cnt] = mk(sst_pkg::KIND_ERROR, '0, '0, '0, line_next,
                          sst_pkg::ERR_UNEXPECTED_END);
            cnt = cnt + 1'b1;
            mode_next = M_HALT;
        end
        else
        begin
            unique case (mode_reg)
                M_STR:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        res[cnt] = mk(sst_pkg::KIND_TEXT, '0, ch_reg, '0, line_next, '0);
                        cnt = cnt + 1'b1;
                    end
                    else if (ch_reg == CH_BACKSLASH)
                    begin
                        esc_next = 1'b1;
                        res[cnt] = mk(sst_pkg::KIND_TEXT, '0, ch_reg, '0, line_next, '0);
                        cnt = cnt + 1'b1;
                    end
                    else if (ch_reg == CH_NL || ch_reg == CH_QUOTE)
                    begin
                        if (ch_reg == CH_NL)
                        begin
                            res[cnt] = mk(sst_pkg::KIND_ERROR, '0, '0, '0, line_next,
                                          sst_pkg::ERR_NEWLINE_IN_STRING);
                            cnt = cnt + 1'b1;
                        end
                        res[cnt] = mk(sst_pkg::KIND_TEXT, '0, CH_QUOTE, '0, line_next, '0);
                        cnt = cnt + 1'b1;
                        res[cnt] = mk(sst_pkg::KIND_TOKEN, sst_pkg::TOK_STRING, '0, '0,
                                      line_next, '0);
                        cnt = cnt + 1'b1;
                        mode_next = M_START;
                    end
                    else
                    begin
                        res[cnt] = mk(sst_pkg::KIND_TEXT, '0, ch_reg, '0, line_next, '0);
                        cnt = cnt + 1'b1;
                    end
                end
                M_NAME:
                begin
                    if (is_alpha(ch_reg) || is_digit(ch_reg))
                    begin
                        store_we = (len_reg < LW'(sst_pkg::KEYWORD_MAX_LEN));
                        store_idx = len_reg;
                        if (len_reg <= LW'(sst_pkg::KEYWORD_MAX_LEN))
                        begin
                            len_next = len_reg + 1'b1;
                        end
                        res[cnt] = mk(sst_pkg::KIND_TEXT, '0, ch_reg, '0, line_next, '0);
                        cnt = cnt + 1'b1;
                    end
                    else
                    begin
                        res[cnt] = mk(sst_pkg::KIND_TOKEN, name_tok, '0, '0, line_next, '0);
                        cnt = cnt + 1'b1;
                        mode_next = M_START;
                        do_start = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (is_digit(ch_reg))
                    begin
                        accum_next = (acc10 > (sst_pkg::NUM_W+4)'(sst_pkg::NUM_MAX))
                                   ? sst_pkg::NUM_MAX : acc10[sst_pkg::NUM_W-1:0];
                    end
                    else
                    begin
                        res[cnt] = mk(sst_pkg::KIND_TOKEN, sst_pkg::TOK_NUMBER, '0, accum_reg,
                                      line_next, '0);
                        cnt = cnt + 1'b1;
                        mode_next = M_START;
                        do_start = 1'b1;
                    end
                end
                M_COMM:
                begin
                    if (ch_reg == CH_NL)
                    begin
                        line_next = line_inc;
                        mode_next = M_START;
                    end
                end
                M_PCT:
                begin
                    if (ch_reg == CH_PERCENT)
                    begin
                        mode_next = M_PCTEND;
                    end
                    else
                    begin
                        res[cnt] = mk(sst_pkg::KIND_ERROR, '0, '0, '0, line_next,
                                      sst_pkg::ERR_BAD_PERCENT);
                        cnt = cnt + 1'b1;
                        mode_next = M_START;
                    end
                end
                M_PCTEND:
                begin
                    if (ch_reg == CH_NL)
                    begin
                        line_next = line_inc;
                        res[cnt] = mk(sst_pkg::KIND_TOKEN, sst_pkg::TOK_SECTION_END, '0, '0,
                                      line_next, '0);
                        cnt = cnt + 1'b1;
                        mode_next = M_HALT;
                    end
                end
                M_BSL:
                begin
                    if (ch_reg == CH_NL)
                    begin
                        line_next = line_inc;
                    end
                    else
                    begin
                        res[cnt] = mk(sst_pkg::KIND_ERROR, '0, '0, '0, line_next,
                                      sst_pkg::ERR_STRAY_BACKSLASH);
                        cnt = cnt + 1'b1;
                    end
                    mode_next = M_START;
                end
                M_START:
                begin
                    do_start = 1'b1;
                end
                default:
                begin
                    mode_next = M_HALT;
                end
            endcase

            if (do_start)
            begin
                if (ch_reg == CH_HASH)
                begin
                    mode_next = M_COMM;
                end
                else if (ch_reg == CH_PERCENT)
                begin
                    mode_next = M_PCT;
                end
                else if (ch_reg == CH_NL)
                begin
                    line_next = line_inc;
                    res[cnt] = mk(sst_pkg::KIND_TOKEN, sst_pkg::TOK_NEWLINE, '0, '0,
                                  line_next, '0);
                    cnt = cnt + 1'b1;
                end
                else if (ch_reg == CH_BACKSLASH)
                begin
                    mode_next = M_BSL;
                end
                else if (ch_reg == CH_QUOTE)
                begin
                    mode_next = M_STR;
                    esc_next = 1'b0;
                    res[cnt] = mk(sst_pkg::KIND_TEXT, '0, CH_QUOTE, '0, line_next, '0);
                    cnt = cnt + 1'b1;
                end
                else if (is_space(ch_reg))
                begin
                    mode_next = M_START;
                end
                else if (is_digit(ch_reg))
                begin
                    mode_next = M_NUM;
                    accum_next = sst_pkg::NUM_W'(digit);
                end
                else if (is_alpha(ch_reg))
                begin
                    mode_next = M_NAME;
                    store_we = 1'b1;
                    store_idx = '0;
                    len_next = LW'(1);
                    res[cnt] = mk(sst_pkg::KIND_TEXT, '0, ch_reg, '0, line_next, '0);
                    cnt = cnt + 1'b1;
                end
                else
                begin
                    res[cnt] = mk(sst_pkg::KIND_ERROR, '0, '0, '0, line_next,
                                  sst_pkg::ERR_ILLEGAL_CHAR);
                    cnt = cnt + 1'b1;
                end
            end
        end

        if (cnt != '0)
        begin
            res[cnt - 1'b1].last = 1'b1;
        end
    end

    assign fire = in_valid_reg && (cnt == '0 || free);
    assign chars.ready = !in_valid_reg || fire;

    assign push.valid = fire && (cnt != '0);
    assign push.cnt = cnt;
    assign push.res = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg <= M_START;
            esc_reg <= 1'b0;
            line_reg <= sst_pkg::LINE_W'(1);
            accum_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            if (chars.valid && chars.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                mode_reg <= mode_next;
                esc_reg <= esc_next;
                line_reg <= line_next;
                accum_reg <= accum_next;
                len_reg <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            ch_reg <= chars.ch;
            eoi_reg <= chars.end_of_input;
        end
        for (int e = 0; e < sst_pkg::KEYWORD_MAX_LEN; e++)
        begin
            if (fire && store_we && store_idx == LW'(e))
            begin
                store_reg[e] <= ch_reg;
            end
        end
    end

endmodule

// ===== hdl/sst_outq.sv =====
// Result register for one bundle of up to three results, sent one per transaction.
// Depends on sst_pkg and sst_out_if.
module sst_outq
(
    input  logic            clk,
    input  logic            rst_n,
    input  sst_pkg::push_t  push,
    output logic            free,
    sst_out_if.source       results
);

    sst_pkg::result_t [sst_pkg::RES_MAX-1:0] res_reg;
    logic [sst_pkg::RES_CNT_W-1:0]           cnt_reg;
    logic [sst_pkg::RES_CNT_W-1:0]           idx_reg;
    sst_pkg::result_t                        cur;
    logic                                    take;
    logic                                    final_take;

    always_comb
    begin
        case (idx_reg)
            2'd0: cur = res_reg[0];
            2'd1: cur = res_reg[1];
            2'd2: cur = res_reg[2];
            default: cur = res_reg[0];
        endcase
    end

    assign results.valid = (cnt_reg != '0);
    assign take = results.valid && results.ready;
    assign final_take = take && (idx_reg == cnt_reg - 1'b1);
    assign free = (cnt_reg == '0) || final_take;

    assign results.kind = cur.kind;
    assign results.token = cur.token;
    assign results.text_char = cur.text_char;
    assign results.number_value = cur.number_value;
    assign results.line_number = cur.line_number;
    assign results.error_code = cur.error_code;
    assign results.last = cur.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                cnt_reg <= push.cnt;
                idx_reg <= '0;
            end
            else if (final_take)
            begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            else if (take)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            res_reg <= push.res;
        end
    end

endmodule

// ===== hdl/screen_spec_tokenizer_top.sv =====
// Top level of the screen spec tokenizer: the scanner core and its result register.
// Depends on sst_pkg, sst_in_if, sst_out_if, sst_core and sst_outq.
//
//   Channel   Direction  Transaction
//   chars     in         one character (ch) or the end-of-input mark
//   results   out        one text character, token or error, last marks the final one
//
// A character is registered on acceptance and scanned in the next cycle; its results
// leave one per cycle from the result register while the receiver is ready, so throughput
// is one character per cycle while each yields at most one result, else the next waits.
// A character with no result never waits on the output side.
// Reset clears the scanner state at once; the name buffer needs no clearing.
// After end of input or a section end, characters are still taken but give no result.
module screen_spec_tokenizer_top
(
    input  logic        clk,
    input  logic        rst_n,
    sst_in_if.sink      chars,
    sst_out_if.source   results
);

    sst_pkg::push_t push;
    logic           free;

    sst_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .push  (push),
        .free  (free)
    );

    sst_outq u_outq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .free    (free),
        .results (results)
    );

endmodule
